### src/khash_pkg.sv
// Shared constants, types and the bucket hash of the k-mer count table.
package khash_pkg;

	// Bucket count must be a power of two no larger than 65536.
	localparam int BUCKETS  = 1024;
	localparam int WAYS     = 8;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W   = $clog2(WAYS + 1);
	localparam int TOTAL_W  = 14;
	localparam int KEY_W    = 64;
	localparam int COUNT_W  = 32;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	typedef logic [BUCKET_W-1:0] bucket_t;
	typedef logic [WAY_W-1:0]    way_t;
	typedef logic [FILL_W-1:0]   fill_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef struct packed {
		logic    key_en;
		logic    count_en;
		bucket_t addr;
		way_t    way;
		key_t    key;
		count_t  count;
	} row_wr_t;

	typedef struct packed {
		logic    en;
		bucket_t addr;
		fill_t   data;
	} fill_wr_t;

	function automatic bucket_t bucket_of(input key_t k);
		logic [31:0] f32;
		logic [15:0] f16;
		f32 = k[31:0] ^ k[63:32];
		f16 = f32[15:0] ^ f32[31:16];
		return f16[BUCKET_W-1:0];
	endfunction

endpackage

### src/kmer_count_hash_table.sv
// Top level of the k-mer count table: command sequencer, way compare and result register.
//
// Each accepted command is handled in order: the bucket row is read from
// memory, the ways are compared, and any update is written back, with the
// result then registered on the output ports, marked by done for one cycle.
// A new command is taken in the cycle the previous result is shown, so
// commands never overlap: each makes a single read-then-write pass over the
// bucket memories. After reset, busy stays high while every entry of the
// bucket fill memory is swept to zero.
// Results cannot be held off, so they must be captured when done is high.
module kmer_count_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      cmd,
	input  logic [63:0]               key,
	input  logic [31:0]               count_in,
	output logic                      busy,
	output logic                      done,
	output logic [31:0]               count_out,
	output logic                      found,
	output logic                      bucket_full,
	output logic [13:0]               entry_total
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                 state_q;
	logic                       accept;
	logic                       clearing;

	logic                       cmd_s1;
	khash_pkg::key_t            key_s1;
	khash_pkg::count_t          count_s1;
	khash_pkg::bucket_t         bucket_s1;

	logic [khash_pkg::WAYS-1:0][khash_pkg::KEY_W-1:0]   key_row;
	logic [khash_pkg::WAYS-1:0][khash_pkg::COUNT_W-1:0] count_row;
	khash_pkg::fill_t           fill_rd;

	logic [khash_pkg::WAYS-1:0] match;
	logic                       hit;
	khash_pkg::way_t            hit_way;
	khash_pkg::count_t          hit_count;

	logic                       hit_s2;
	khash_pkg::way_t            way_s2;
	khash_pkg::fill_t           fill_s2;
	khash_pkg::count_t          hit_count_s2;

	logic                       do_insert;
	logic                       do_full;
	khash_pkg::total_t          total_q;
	khash_pkg::total_t          total_next;
	khash_pkg::row_wr_t         row_wr;
	khash_pkg::fill_wr_t        fill_wr;

	assign busy   = (state_q != ST_IDLE) || clearing;
	assign accept = start && !busy;

	khash_bucket_mem u_bucket_mem (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (khash_pkg::bucket_of(key)),
		.wr       (row_wr),
		.key_row  (key_row),
		.count_row(count_row)
	);

	khash_fill_mem u_fill_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (khash_pkg::bucket_of(key)),
		.wr      (fill_wr),
		.rd_data (fill_rd),
		.clearing(clearing)
	);

	always_comb begin
		for (int i = 0; i < khash_pkg::WAYS; i++) begin
			match[i] = (key_row[i] == key_s1) &&
				(khash_pkg::FILL_W'(i) < fill_rd);
		end
		hit     = 1'b0;
		hit_way = '0;
		for (int i = khash_pkg::WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_way = khash_pkg::WAY_W'(i);
			end
		end
		hit_count = count_row[hit_way];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd;
			key_s1    <= key;
			count_s1  <= count_in;
			bucket_s1 <= khash_pkg::bucket_of(key);
		end
		if (state_q == ST_LOOK) begin
			hit_s2       <= hit;
			way_s2       <= hit_way;
			fill_s2      <= fill_rd;
			hit_count_s2 <= hit_count;
		end
	end

	always_comb begin
		do_insert = (state_q == ST_UPD) && (cmd_s1 == khash_pkg::CMD_PUT) && !hit_s2 &&
			(fill_s2 < khash_pkg::FILL_W'(khash_pkg::WAYS));
		do_full   = (cmd_s1 == khash_pkg::CMD_PUT) && !hit_s2 &&
			(fill_s2 >= khash_pkg::FILL_W'(khash_pkg::WAYS));
		total_next = do_insert ? total_q + 1'b1 : total_q;

		row_wr.key_en   = do_insert;
		row_wr.count_en = (state_q == ST_UPD) && (cmd_s1 == khash_pkg::CMD_PUT) &&
			(hit_s2 || do_insert);
		row_wr.addr     = bucket_s1;
		row_wr.way      = hit_s2 ? way_s2 : fill_s2[khash_pkg::WAY_W-1:0];
		row_wr.key      = key_s1;
		row_wr.count    = count_s1;

		fill_wr.en   = do_insert;
		fill_wr.addr = bucket_s1;
		fill_wr.data = fill_s2 + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done    <= 1'b0;
		end else begin
			total_q <= total_next;
			done    <= (state_q == ST_UPD);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			count_out   <= ((cmd_s1 == khash_pkg::CMD_GET) && hit_s2) ? hit_count_s2 : '0;
			found       <= hit_s2;
			bucket_full <= do_full;
			entry_total <= total_next;
		end
	end

endmodule

### src/khash_bucket_mem.sv
// Key and count memories, one row per bucket with one lane per way.
module khash_bucket_mem (
	input  logic                                         clk,
	input  logic                                         rd_en,
	input  khash_pkg::bucket_t                           rd_addr,
	input  khash_pkg::row_wr_t                           wr,
	output logic [khash_pkg::WAYS-1:0][khash_pkg::KEY_W-1:0]   key_row,
	output logic [khash_pkg::WAYS-1:0][khash_pkg::COUNT_W-1:0] count_row
);

	logic [khash_pkg::WAYS-1:0][khash_pkg::KEY_W-1:0]   key_mem   [khash_pkg::BUCKETS];
	logic [khash_pkg::WAYS-1:0][khash_pkg::COUNT_W-1:0] count_mem [khash_pkg::BUCKETS];

	always_ff @(posedge clk) begin
		if (wr.key_en) begin
			key_mem[wr.addr][wr.way] <= wr.key;
		end
		if (wr.count_en) begin
			count_mem[wr.addr][wr.way] <= wr.count;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_row   <= key_mem[rd_addr];
			count_row <= count_mem[rd_addr];
		end
	end

endmodule

### src/khash_fill_mem.sv
// Per-bucket fill memory with a clearing sweep after reset.
module khash_fill_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  khash_pkg::bucket_t   rd_addr,
	input  khash_pkg::fill_wr_t  wr,
	output khash_pkg::fill_t     rd_data,
	output logic                 clearing
);

	khash_pkg::fill_t   fill_mem [khash_pkg::BUCKETS];
	khash_pkg::bucket_t clr_addr_q;
	logic               clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == khash_pkg::BUCKET_W'(khash_pkg::BUCKETS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			fill_mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			fill_mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= fill_mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule
